// File: rtl/mpcm_pkg.sv
// Shared constants, codes and types of the multi-pattern command matcher.
package mpcm_pkg;

    // Pattern store geometry.
    localparam int NUM_PATTERNS = 8;
    localparam int PATTERN_LEN  = 16;
    localparam int POS_W        = $clog2(PATTERN_LEN);
    localparam int CNT_W        = $clog2(PATTERN_LEN + 1);

    // Special pattern characters.
    localparam logic [7:0] WILDCARD_CHAR = 8'h09;
    localparam logic [7:0] END_CHAR      = 8'h00;

    // Register reset values.
    localparam logic [3:0]  PATTERNS_RESET = 4'd8;
    localparam logic [31:0] TIMEOUT_RESET  = 32'd10000;
    localparam logic [15:0] MAX_LEN_RESET  = 16'd256;

    // Input word actions.
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_BYTE = 1'b1;

    // Result event codes.
    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_CMD     = 2'd1;
    localparam logic [1:0] EV_PAYLOAD = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PATTERNS = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT  = 2'd1;
    localparam logic [1:0] CFG_MAX_LEN  = 2'd2;

    // Control shared by all pattern slots for one word.
    typedef struct packed {
        logic             step;     // a received byte is retired this cycle
        logic             match;    // the byte is matched against the patterns
        logic             zero;     // match counts are cleared for this byte
        logic [7:0]       rx;       // received byte
        logic [7:0]       last;     // last matched byte before this one
        logic [POS_W-1:0] wr_pos;   // pattern character position to load
        logic [7:0]       wr_char;  // pattern character to load
    } slot_ctl_t;

endpackage

// File: rtl/mpcm_slot.sv
// One pattern slot: character row, per-position compare cells and match count.
module mpcm_slot (
    input  logic               clk,
    input  logic               rst_n,
    input  mpcm_pkg::slot_ctl_t ctl,
    input  logic               wr_en,
    input  logic               slot_en,
    input  logic               lower_hit,
    output logic               hit,
    output logic               done
);
    import mpcm_pkg::*;

    logic [7:0]             row_reg [PATTERN_LEN];
    logic [CNT_W-1:0]       cnt_reg;
    logic [CNT_W-1:0]       cnt_next;
    logic [CNT_W-1:0]       cnt_eff;
    logic [CNT_W-1:0]       cnt_inc;
    logic [PATTERN_LEN-1:0] char_ok;
    logic [PATTERN_LEN:0]   term;
    logic                   char_sel;
    logic                   restart;
    logic [7:0]             prev_char;

    // Pattern characters; contents are undefined until loaded.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            row_reg[ctl.wr_pos] <= ctl.wr_char;
        end
    end

    // Every stored character is compared with the byte in its own cell.
    always_comb
    begin
        for (int p = 0; p < PATTERN_LEN; p++)
        begin
            char_ok[p] = (row_reg[p] == ctl.rx) || (row_reg[p] == WILDCARD_CHAR);
            term[p]    = (row_reg[p] == END_CHAR);
        end
        term[PATTERN_LEN] = 1'b1;
    end

    // Select the cell at the current count and decide the next count.
    always_comb
    begin
        cnt_eff   = ctl.zero ? '0 : cnt_reg;
        cnt_inc   = CNT_W'(cnt_eff + 1'b1);
        char_sel  = (cnt_eff < CNT_W'(PATTERN_LEN)) ? char_ok[cnt_eff[POS_W-1:0]] : 1'b0;
        hit       = slot_en && ctl.match && char_sel;
        done      = hit && ((cnt_inc <= CNT_W'(PATTERN_LEN)) ? term[cnt_inc] : 1'b1);
        // A match in a lower slot on this byte has already moved the last char.
        prev_char = lower_hit ? ctl.rx : ctl.last;
        restart   = (prev_char == row_reg[0]);
        if (ctl.match)
        begin
            if (hit)
            begin
                cnt_next = cnt_inc;
            end
            else if (restart)
            begin
                cnt_next = CNT_W'(1);
            end
            else
            begin
                cnt_next = '0;
            end
        end
        else
        begin
            cnt_next = cnt_eff;
        end
    end

    // Match count register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (ctl.step && slot_en)
        begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

// File: rtl/multi_pattern_command_matcher.sv
// Top level of the multi-pattern command matcher with payload hand-off.
//
//  Channel  Handshake              Carries
//  -------  ---------------------  ------------------------------------------------
//  input    in_valid / in_ready    action, pattern load fields, rx_byte, time_ms,
//                                  payload_end
//  output   out_valid / out_ready  event_res, command_id, payload fields, timed_out
//  config   cfg_we                 cfg_index, cfg_data (written at once, no read-back)
//
// A word is held in the input register and its result is registered in the output
// register, so one word per cycle is sustained while the output is not stalled; all
// slots compare the byte in parallel in a single pass.
// Reset clears the control state and counts and loads the configuration reset values;
// the pattern store is not cleared and must be loaded before use.
// A stalled result holds the output register; one more word is then taken into
// the input register, and pattern loads keep retiring during the stall.
module multi_pattern_command_matcher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [2:0]  pattern_slot,
    input  logic [3:0]  pattern_pos,
    input  logic [7:0]  pattern_char,
    input  logic [7:0]  rx_byte,
    input  logic [31:0] time_ms,
    input  logic        payload_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  event_res,
    output logic [2:0]  command_id,
    output logic [7:0]  payload_byte,
    output logic [15:0] payload_offset,
    output logic        payload_last,
    output logic        timed_out,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import mpcm_pkg::*;

    // Input register.
    logic        in_full_reg;
    logic        act_reg;
    logic [2:0]  slot_reg;
    logic [3:0]  pos_reg;
    logic [7:0]  pch_reg;
    logic [7:0]  rx_reg;
    logic [31:0] time_reg;
    logic        pend_reg;

    // Configuration registers.
    logic [3:0]  pin_reg;
    logic [31:0] timeout_reg;
    logic [15:0] max_len_reg;

    // Matcher state.
    logic        mode_reg, mode_next;
    logic [2:0]  active_reg, active_next;
    logic [15:0] pcount_reg, pcount_next;
    logic [31:0] tstart_reg, tstart_next;
    logic [7:0]  last_reg, last_next;

    // Output register.
    logic        out_valid_reg;
    logic [1:0]  ev_reg, ev_next;
    logic [2:0]  cmd_reg, cmd_next;
    logic [7:0]  pbyte_reg, pbyte_next;
    logic [15:0] poff_reg, poff_next;
    logic        plast_reg, plast_next;
    logic        tout_reg, tout_next;

    // Working signals.
    logic                    accept;
    logic                    advance;
    logic                    is_byte;
    logic                    byte_step;
    logic [31:0]             elapsed;
    logic                    timeout_hit;
    logic                    mode_eff;
    logic [16:0]             pay_next;
    logic                    pay_last;
    logic                    any_hit;
    logic                    any_done;
    logic [2:0]              top_id;
    slot_ctl_t               ctl;
    logic [NUM_PATTERNS-1:0] slot_en;
    logic [NUM_PATTERNS-1:0] wr_en;
    logic [NUM_PATTERNS-1:0] lower_hit;
    logic [NUM_PATTERNS-1:0] hit;
    logic [NUM_PATTERNS-1:0] done;

    // Handshake: a load always retires, a byte needs room in the output register.
    always_comb
    begin
        is_byte   = in_full_reg && (act_reg == ACT_BYTE);
        advance   = in_full_reg && ((act_reg == ACT_LOAD) || !out_valid_reg || out_ready);
        byte_step = advance && is_byte;
        in_ready  = !in_full_reg || advance;
        accept    = in_valid && in_ready;
    end

    // Timeout check and payload length check.
    always_comb
    begin
        elapsed     = time_reg - tstart_reg;
        timeout_hit = mode_reg && (elapsed >= timeout_reg);
        mode_eff    = mode_reg && !timeout_hit;
        pay_next    = {1'b0, pcount_reg} + 17'd1;
        pay_last    = pend_reg || (pay_next >= {1'b0, max_len_reg});
    end

    // Control word for the slots.
    always_comb
    begin
        ctl.step    = byte_step;
        ctl.match   = byte_step && !mode_eff;
        ctl.zero    = timeout_hit || (mode_eff && pay_last);
        ctl.rx      = rx_reg;
        ctl.last    = last_reg;
        ctl.wr_pos  = POS_W'(pos_reg);
        ctl.wr_char = pch_reg;
    end

    // Pattern slots, each with its enable, load strobe and lower-slot hit chain.
    for (genvar g = 0; g < NUM_PATTERNS; g++)
    begin : g_slot
        assign slot_en[g] = (g < int'(pin_reg));
        assign wr_en[g]   = advance && (act_reg == ACT_LOAD) && (int'(slot_reg) == g)
                            && (int'(pos_reg) < PATTERN_LEN);
        if (g == 0)
        begin : g_first
            assign lower_hit[g] = 1'b0;
        end
        else
        begin : g_rest
            assign lower_hit[g] = lower_hit[g-1] | hit[g-1];
        end

        mpcm_slot u_slot (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .wr_en     (wr_en[g]),
            .slot_en   (slot_en[g]),
            .lower_hit (lower_hit[g]),
            .hit       (hit[g]),
            .done      (done[g])
        );
    end

    // The highest slot that completes becomes the active command.
    always_comb
    begin
        any_hit  = |hit;
        any_done = |done;
        top_id   = '0;
        for (int i = 0; i < NUM_PATTERNS; i++)
        begin
            if (done[i])
            begin
                top_id = 3'(i);
            end
        end
    end

    // Next matcher state and result word.
    always_comb
    begin
        mode_next   = mode_reg;
        active_next = active_reg;
        pcount_next = pcount_reg;
        tstart_next = tstart_reg;
        last_next   = last_reg;
        if (byte_step)
        begin
            if (!mode_reg || timeout_hit)
            begin
                tstart_next = time_reg;
            end
            if (mode_eff)
            begin
                pcount_next = pay_next[15:0];
                if (pay_last)
                begin
                    mode_next = 1'b0;
                end
            end
            else
            begin
                mode_next = 1'b0;
                if (any_hit)
                begin
                    last_next = rx_reg;
                end
                if (any_done)
                begin
                    mode_next   = 1'b1;
                    active_next = top_id;
                    pcount_next = '0;
                end
            end
        end

        if (mode_eff)
        begin
            ev_next  = EV_PAYLOAD;
            cmd_next = active_reg;
        end
        else if (any_done)
        begin
            ev_next  = EV_CMD;
            cmd_next = top_id;
        end
        else
        begin
            ev_next  = EV_NONE;
            cmd_next = '0;
        end
        pbyte_next = mode_eff ? rx_reg : 8'd0;
        poff_next  = mode_eff ? pcount_reg : 16'd0;
        plast_next = mode_eff && pay_last;
        tout_next  = timeout_hit;
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_full_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg  <= action;
            slot_reg <= pattern_slot;
            pos_reg  <= pattern_pos;
            pch_reg  <= pattern_char;
            rx_reg   <= rx_byte;
            time_reg <= time_ms;
            pend_reg <= payload_end;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pin_reg     <= PATTERNS_RESET;
            timeout_reg <= TIMEOUT_RESET;
            max_len_reg <= MAX_LEN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PATTERNS: pin_reg     <= cfg_data[3:0];
                CFG_TIMEOUT:  timeout_reg <= cfg_data;
                CFG_MAX_LEN:  max_len_reg <= cfg_data[15:0];
                default:      ;
            endcase
        end
    end

    // Matcher state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            active_reg <= '0;
            pcount_reg <= '0;
            tstart_reg <= '0;
            last_reg   <= '0;
        end
        else
        begin
            mode_reg   <= mode_next;
            active_reg <= active_next;
            pcount_reg <= pcount_next;
            tstart_reg <= tstart_next;
            last_reg   <= last_next;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (byte_step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_step)
        begin
            ev_reg    <= ev_next;
            cmd_reg   <= cmd_next;
            pbyte_reg <= pbyte_next;
            poff_reg  <= poff_next;
            plast_reg <= plast_next;
            tout_reg  <= tout_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign event_res      = ev_reg;
    assign command_id     = cmd_reg;
    assign payload_byte   = pbyte_reg;
    assign payload_offset = poff_reg;
    assign payload_last   = plast_reg;
    assign timed_out      = tout_reg;

endmodule

// File: rtl/mpcm_checker.sv
// Port-level checks of the command matcher and their attachment to the top level.
module mpcm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  event_res,
    input logic [2:0]  command_id,
    input logic [7:0]  payload_byte,
    input logic [15:0] payload_offset,
    input logic        payload_last,
    input logic        timed_out
);
    import mpcm_pkg::*;

    // A stalled result stays valid and holds its event, command, offset and last flag until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_res)
            && $stable(command_id) && $stable(payload_offset) && $stable(payload_last))
        else $error("result word changed while stalled");

    // Only the three defined events are reported.
    a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (event_res == EV_NONE) || (event_res == EV_CMD)
            || (event_res == EV_PAYLOAD))
        else $error("undefined event code");

    // Payload fields stay zero outside payload words.
    a_payload_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res != EV_PAYLOAD) |->
            (payload_byte == 8'd0) && (payload_offset == 16'd0) && !payload_last)
        else $error("payload fields set outside a payload word");

    // A timeout leaves payload mode, so it never comes with a payload word,
    // and an empty result names no command.
    a_timeout_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(timed_out && (event_res == EV_PAYLOAD))
            && ((event_res != EV_NONE) || (command_id == 3'd0)))
        else $error("timeout on a payload word or command on an empty word");

endmodule

bind multi_pattern_command_matcher mpcm_checker u_mpcm_checker (.*);

// File: bench/tb_top.sv
// Self-checking bench for the multi-pattern command matcher with a scoreboard class.
module tb_top;
    import mpcm_pkg::*;

    // One input word as it crosses the input handshake.
    typedef struct packed {
        logic        act;
        logic [2:0]  slot;
        logic [3:0]  pos;
        logic [7:0]  pch;
        logic [7:0]  rx;
        logic [31:0] now;
        logic        pend;
    } word_t;

    // One result word as it crosses the output handshake.
    typedef struct packed {
        logic [1:0]  ev;
        logic [2:0]  cmd;
        logic [7:0]  pbyte;
        logic [15:0] poff;
        logic        plast;
        logic        tout;
    } result_t;

    // Tracks the matcher state and queues the result each processed byte must give.
    class match_scoreboard;
        logic [7:0]       pattern_mem [NUM_PATTERNS*PATTERN_LEN];
        logic [CNT_W-1:0] depth [NUM_PATTERNS];
        bit               in_payload;
        logic [2:0]       owner;
        logic [15:0]      pay_count;
        logic [31:0]      window_start;
        logic [7:0]       last_hit;
        logic [3:0]       slots_used;
        logic [31:0]      timeout_lim;
        logic [15:0]      len_limit;
        result_t          expected_q[$];
        int               errors;

        function new();
            foreach (pattern_mem[i]) pattern_mem[i] = '0;
            foreach (depth[i]) depth[i] = '0;
            in_payload   = 1'b0;
            owner        = '0;
            pay_count    = '0;
            window_start = '0;
            last_hit     = '0;
            slots_used   = PATTERNS_RESET;
            timeout_lim  = TIMEOUT_RESET;
            len_limit    = MAX_LEN_RESET;
            errors       = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                CFG_PATTERNS: slots_used  = val[3:0];
                CFG_TIMEOUT:  timeout_lim = val;
                CFG_MAX_LEN:  len_limit   = val[15:0];
                default: ;
            endcase
        endfunction

        function int active_slots();
            return (slots_used > NUM_PATTERNS) ? NUM_PATTERNS : int'(slots_used);
        endfunction

        // Positions at or past the pattern length read as a terminator.
        function logic [7:0] char_at(int slot, int pos);
            if (pos >= PATTERN_LEN)
                return END_CHAR;
            return pattern_mem[slot*PATTERN_LEN + pos];
        endfunction

        function void drop_counts();
            for (int i = 0; i < active_slots(); i++)
                depth[i] = '0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Note an accepted input word and queue the result it causes, if any.
        function void note_word(word_t w);
            result_t     r;
            int          n;
            int          cnt;
            logic [7:0]  pc;
            int unsigned nxt;
            r = '0;
            if (w.act == ACT_LOAD) begin
                pattern_mem[int'(w.slot)*PATTERN_LEN + int'(w.pos)] = w.pch;
                return;
            end

            // The timeout is checked before the byte is looked at.
            if (!in_payload) begin
                window_start = w.now;
            end else if (32'(w.now - window_start) >= timeout_lim) begin
                window_start = w.now;
                in_payload   = 1'b0;
                drop_counts();
                r.tout = 1'b1;
            end

            if (!in_payload) begin
                // Slots are walked upward; a lower hit updates the restart char.
                n = active_slots();
                for (int i = 0; i < n; i++) begin
                    cnt = int'(depth[i]);
                    pc  = char_at(i, cnt);
                    if (cnt < PATTERN_LEN && (w.rx == pc || pc == WILDCARD_CHAR)) begin
                        last_hit = w.rx;
                        cnt++;
                        depth[i] = cnt[CNT_W-1:0];
                        if (char_at(i, cnt) == END_CHAR) begin
                            owner      = i[2:0];
                            in_payload = 1'b1;
                            pay_count  = '0;
                            r.ev       = EV_CMD;
                        end
                    end else if (last_hit == char_at(i, 0)) begin
                        depth[i] = CNT_W'(1);
                    end else begin
                        depth[i] = '0;
                    end
                end
                if (r.ev == EV_CMD)
                    r.cmd = owner;
            end else begin
                nxt     = pay_count + 32'd1;
                r.ev    = EV_PAYLOAD;
                r.cmd   = owner;
                r.pbyte = w.rx;
                r.poff  = pay_count;
                if (w.pend || nxt >= len_limit) begin
                    in_payload = 1'b0;
                    drop_counts();
                    r.plast = 1'b1;
                end
                pay_count = nxt[15:0];
            end
            expected_q.push_back(r);
        endfunction

        function void compare(string name, logic [31:0] exp, logic [31:0] act);
            if (act !== exp) begin
                $error("%s mismatch: expected %0d, got %0d", name, exp, act);
                errors++;
            end
        endfunction

        // Compare an accepted result word with the oldest prediction.
        function void check_result(result_t got);
            result_t exp;
            if (expected_q.size() == 0) begin
                $error("result word arrived with no prediction pending");
                errors++;
                return;
            end
            exp = expected_q.pop_front();
            compare("event_res", 32'(exp.ev), 32'(got.ev));
            compare("command_id", 32'(exp.cmd), 32'(got.cmd));
            compare("payload_byte", 32'(exp.pbyte), 32'(got.pbyte));
            compare("payload_offset", 32'(exp.poff), 32'(got.poff));
            compare("payload_last", 32'(exp.plast), 32'(got.plast));
            compare("timed_out", 32'(exp.tout), 32'(got.tout));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        action;
    logic [2:0]  pattern_slot;
    logic [3:0]  pattern_pos;
    logic [7:0]  pattern_char;
    logic [7:0]  rx_byte;
    logic [31:0] time_ms;
    logic        payload_end;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  event_res;
    logic [2:0]  command_id;
    logic [7:0]  payload_byte;
    logic [15:0] payload_offset;
    logic        payload_last;
    logic        timed_out;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    match_scoreboard sb = new();
    logic [31:0]     now_ms;
    int              words_sent;
    bit              rx_calm;
    bit              tx_calm;

    multi_pattern_command_matcher dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .pattern_slot   (pattern_slot),
        .pattern_pos    (pattern_pos),
        .pattern_char   (pattern_char),
        .rx_byte        (rx_byte),
        .time_ms        (time_ms),
        .payload_end    (payload_end),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .event_res      (event_res),
        .command_id     (command_id),
        .payload_byte   (payload_byte),
        .payload_offset (payload_offset),
        .payload_last   (payload_last),
        .timed_out      (timed_out),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #5 clk = ~clk;

    // Idle cycles before a word; calm stretches never idle.
    function automatic int draw_gap(bit calm);
        if (calm || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 19);
    endfunction

    // Bytes that mostly fall inside the pattern alphabet.
    function automatic logic [7:0] pick_noise();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'($urandom_range(0, 255));
        if (r == 1)
            return WILDCARD_CHAR;
        return 8'h41 + 8'($urandom_range(0, 3));
    endfunction

    // Time advance per byte, landing on the timeout boundary now and then.
    function automatic logic [31:0] time_step();
        int r;
        r = $urandom_range(0, 59);
        if (r == 0)
            return sb.timeout_lim;
        if (r == 1)
            return sb.timeout_lim - 32'd1;
        if (r == 2)
            return $urandom();
        return 32'($urandom_range(0, 3));
    endfunction

    // Random command text: mostly short, a few single-char, long or unterminated.
    function automatic string random_text();
        string      s;
        int         len;
        int         r;
        logic [7:0] ch;
        s = "AAAAAAAAAAAAAAAA";
        r = $urandom_range(0, 9);
        if (r == 0)
            len = PATTERN_LEN;
        else if (r == 1)
            len = 1;
        else if (r == 2)
            len = $urandom_range(5, PATTERN_LEN - 1);
        else
            len = $urandom_range(2, 4);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 5) == 0)
                ch = WILDCARD_CHAR;
            else
                ch = 8'h41 + 8'($urandom_range(0, 3));
            s.putc(i, ch);
        end
        return s.substr(0, len - 1);
    endfunction

    function automatic word_t make_load(logic [2:0] slot, logic [3:0] pos, logic [7:0] ch);
        word_t w;
        w.act  = ACT_LOAD;
        w.slot = slot;
        w.pos  = pos;
        w.pch  = ch;
        w.rx   = 8'($urandom_range(0, 255));
        w.now  = $urandom();
        w.pend = 1'($urandom_range(0, 1));
        return w;
    endfunction

    // Present one word and hold it until the block takes it.
    task automatic send_word(word_t w);
        int gap;
        gap = draw_gap(rx_calm);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        action       <= w.act;
        pattern_slot <= w.slot;
        pattern_pos  <= w.pos;
        pattern_char <= w.pch;
        rx_byte      <= w.rx;
        time_ms      <= w.now;
        payload_end  <= w.pend;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_word(w);
        words_sent++;
    endtask

    // Send a received byte after moving the clock on by dt milliseconds.
    task automatic send_rx(logic [7:0] ch, logic pend, logic [31:0] dt);
        word_t w;
        now_ms = now_ms + dt;
        w.act  = ACT_BYTE;
        w.slot = 3'($urandom_range(0, 7));
        w.pos  = 4'($urandom_range(0, 15));
        w.pch  = 8'($urandom_range(0, 255));
        w.rx   = ch;
        w.now  = now_ms;
        w.pend = pend;
        send_word(w);
    endtask

    // Write a whole slot: text, terminator if it fits, random fill after it.
    task automatic load_text(int slot, string s);
        logic [7:0] ch;
        for (int p = 0; p < PATTERN_LEN; p++) begin
            if (p < s.len())
                ch = s[p];
            else if (p == s.len())
                ch = END_CHAR;
            else
                ch = 8'($urandom_range(0, 255));
            send_word(make_load(slot[2:0], p[3:0], ch));
        end
    endtask

    // Replay the stored text of a slot, with random bytes for wildcards and an occasional noise byte.
    task automatic send_command_text(int slot);
        int         p;
        logic [7:0] ch;
        p = 0;
        while (p < PATTERN_LEN && sb.char_at(slot, p) != END_CHAR) begin
            ch = sb.char_at(slot, p);
            if (ch == WILDCARD_CHAR)
                ch = 8'($urandom_range(0, 255));
            else if ($urandom_range(0, 11) == 0)
                ch = pick_noise();
            send_rx(ch, 1'($urandom_range(0, 1)), time_step());
            p++;
        end
    endtask

    // Stop sending and wait until every predicted result has come out.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Result side: random stalls, check every accepted result word.
    initial begin : result_sink
        int      gap;
        result_t got;
        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever begin
            gap = draw_gap(tx_calm);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            got.ev    = event_res;
            got.cmd   = command_id;
            got.pbyte = payload_byte;
            got.poff  = payload_offset;
            got.plast = payload_last;
            got.tout  = timed_out;
            sb.check_result(got);
        end
    end

    // Watchdog against a hung handshake.
    initial begin : watchdog
        #8000000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        string       dir_txt [NUM_PATTERNS];
        int unsigned ph_use [10];
        int unsigned ph_tmo [10];
        int unsigned ph_len [10];
        int          target;
        int          r;
        int          k;
        dir_txt = '{"AB", "XY", "\tZ", "AAC", "CA", "\tB", "K",
                    "D\t\t\t\t\t\t\t\t\t\t\t\t\t\t\t"};
        ph_use  = '{8, 3, 1, 8, 0, 15, 5, 2, 8, 6};
        ph_tmo  = '{20, 32'hFFFF_FFFF, 0, 10000, 50, 7, 30, 1, 100, 15};
        ph_len  = '{4, 0, 1, 65535, 8, 2, 16, 5, 1, 65535};

        in_valid     <= 1'b0;
        action       <= ACT_LOAD;
        pattern_slot <= '0;
        pattern_pos  <= '0;
        pattern_char <= '0;
        rx_byte      <= '0;
        time_ms      <= '0;
        payload_end  <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        rst_n        <= 1'b0;
        now_ms       = 32'hFFFF_FFFE;
        words_sent   = 0;
        rx_calm      = 1'b0;
        tx_calm      = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed setup: short timeout and length so every ending shows up.
        write_reg(CFG_PATTERNS, 32'd8);
        write_reg(CFG_TIMEOUT, 32'd5);
        write_reg(CFG_MAX_LEN, 32'd3);
        for (int s = 0; s < NUM_PATTERNS; s++)
            load_text(s, dir_txt[s]);

        // Two slots complete on the same byte; payload ends by consumer flag.
        send_rx("A", 1'b0, 32'd1);
        send_rx("B", 1'b0, 32'd1);
        send_rx(8'h00, 1'b0, 32'd1);
        send_rx(8'hFF, 1'b1, 32'd1);
        // Single-char command; payload ends at the length limit.
        send_rx("K", 1'b0, 32'd1);
        send_rx(8'h55, 1'b0, 32'd1);
        send_rx(8'hAA, 1'b0, 32'd1);
        send_rx(8'h0F, 1'b0, 32'd1);
        // Wildcard first char, then a timeout.
        send_rx("Q", 1'b0, 32'd1);
        send_rx("Z", 1'b0, 32'd1);
        send_rx("K", 1'b1, 32'd5);
        send_rx(8'hF0, 1'b1, 32'd4);
        // Broken partial matches that restart on the remembered char.
        send_rx("A", 1'b0, 32'd1);
        send_rx("A", 1'b0, 32'd1);
        send_rx("A", 1'b0, 32'd1);
        send_rx("C", 1'b0, 32'd1);
        send_rx("A", 1'b0, 32'd1);
        send_rx(WILDCARD_CHAR, 1'b1, 32'd1);
        send_rx(WILDCARD_CHAR, 1'b0, 32'd1);

        // Random phases, each with its own register setting and idle behavior.
        for (int ph = 0; ph < 10; ph++) begin
            drain();
            write_reg(CFG_PATTERNS, ph_use[ph]);
            write_reg(CFG_TIMEOUT, ph_tmo[ph]);
            write_reg(CFG_MAX_LEN, ph_len[ph]);
            rx_calm = ($urandom_range(0, 3) == 0);
            tx_calm = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 2))
                load_text($urandom_range(0, NUM_PATTERNS - 1), random_text());
            target = words_sent + 110;
            while (words_sent < target) begin
                if (sb.in_payload) begin
                    send_rx(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0),
                            time_step());
                end else begin
                    r = $urandom_range(0, 39);
                    if (r == 0)
                        send_word(make_load(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                                            8'($urandom_range(0, 255))));
                    else if (r < 24)
                        send_command_text($urandom_range(0, NUM_PATTERNS - 1));
                    else
                        send_rx(pick_noise(), 1'($urandom_range(0, 1)), time_step());
                end
            end
        end

        // Let the last results out, then give the verdict.
        in_valid <= 1'b0;
        k = 0;
        while (k < 5000 && sb.pending() != 0) begin
            @(posedge clk);
            k++;
        end
        repeat (10) @(posedge clk);
        if (sb.pending() != 0) begin
            $error("%0d predicted results never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: filelist.f
rtl/mpcm_pkg.sv
rtl/mpcm_slot.sv
rtl/multi_pattern_command_matcher.sv
rtl/mpcm_checker.sv
bench/tb_top.sv
